// ===== design/cspan_pkg.sv =====
// Shared types and constants for the column to span converter.
// No dependencies; used by every module of the block.
package cspan_pkg;

    localparam int ROWS_DEF    = 64;
    localparam int COLUMNS_DEF = 512;

    localparam int XW  = 10;  // column index width
    localparam int SXW = 9;   // span column width
    localparam int RW  = 7;   // working row width, one above the 6-bit row field
    localparam logic [RW-1:0] NO_ROW = 7'h7F;

    localparam int JQ_DEPTH = 2;
    localparam int JQ_AW    = $clog2(JQ_DEPTH);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic [9:0] col_x;
        logic [5:0] col_top;
        logic [5:0] col_bottom;
        logic       col_empty;
    } col_t;

    typedef struct packed {
        logic [5:0] span_row;
        logic [8:0] span_x_start;
        logic [8:0] span_x_end;
        logic       span_last;
    } span_t;

    // one column after classification: previous and new row ranges
    typedef struct packed {
        logic [XW-1:0] x;
        logic [RW-1:0] t1;
        logic [RW-1:0] b1;
        logic [RW-1:0] t2;
        logic [RW-1:0] b2;
    } job_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } bk_state_t;

endpackage

// ===== design/column_to_span_converter_core.sv =====
// Top level of the column to span converter.
// Instantiates cspan_front and cspan_back; depends on cspan_pkg.
//
// Columns of a plane go in left to right; each closed row comes out as one span
// (row, start column, end column), with span_last on the final span of a column.
// The back end handles one row per cycle, though a closing row waits while the result
// queue has no room; it walks each row that a column closes or newly opens, then retires
// the column. The single-port row start memory and the row walk in the back end set the
// pace. A two-deep column queue and a four-deep result queue let both sides stall
// independently. A plane must finish with an empty column, which closes every row still
// open.
module column_to_span_converter_core #(
    parameter int ROWS    = cspan_pkg::ROWS_DEF,
    parameter int COLUMNS = cspan_pkg::COLUMNS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cspan_pkg::col_t  col,
    input  logic             push,
    output logic             full,
    output cspan_pkg::span_t span,
    output logic             empty,
    input  logic             pop
);

    cspan_pkg::job_t job;
    logic            job_valid;
    logic            job_pop;

    cspan_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .col       (col),
        .push      (push),
        .full      (full),
        .job       (job),
        .job_valid (job_valid),
        .job_pop   (job_pop)
    );

    cspan_back #(
        .ROWS (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .span      (span),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

// ===== design/cspan_front.sv =====
// Front end: accepts columns, saturates them, pairs them with the previous range.
// Holds the short job queue toward the back end. Depends on cspan_pkg.
module cspan_front #(
    parameter int ROWS    = cspan_pkg::ROWS_DEF,
    parameter int COLUMNS = cspan_pkg::COLUMNS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cspan_pkg::col_t    col,
    input  logic               push,
    output logic               full,
    output cspan_pkg::job_t    job,
    output logic               job_valid,
    input  logic               job_pop
);

    localparam logic [cspan_pkg::XW:0] COL_LIM = (cspan_pkg::XW + 1)'(COLUMNS);
    localparam logic [5:0]             ROW_MAX = 6'(ROWS - 1);

    logic       prev_empty_reg, prev_empty_next;
    logic [5:0] prev_top_reg, prev_top_next;
    logic [5:0] prev_bottom_reg, prev_bottom_next;

    cspan_pkg::job_t jq_mem [cspan_pkg::JQ_DEPTH];
    logic [cspan_pkg::JQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [cspan_pkg::JQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [cspan_pkg::JQ_AW:0]   cnt_reg, cnt_next;

    logic                     accept;
    logic                     deq;
    logic [cspan_pkg::XW-1:0] x_sat;
    logic [5:0]               b_sat;
    cspan_pkg::job_t          job_new;

    assign full      = (cnt_reg == (cspan_pkg::JQ_AW + 1)'(cspan_pkg::JQ_DEPTH));
    assign job_valid = (cnt_reg != '0);
    assign accept    = push && !full;
    assign deq       = job_pop && job_valid;
    assign job       = jq_mem[rd_ptr_reg];

    always_comb
    begin
        x_sat = ({1'b0, col.col_x} > COL_LIM) ? COL_LIM[cspan_pkg::XW-1:0] : col.col_x;
        b_sat = (col.col_bottom > ROW_MAX) ? ROW_MAX : col.col_bottom;

        job_new.x  = x_sat;
        job_new.t2 = col.col_empty ? cspan_pkg::NO_ROW : {1'b0, col.col_top};
        job_new.b2 = col.col_empty ? '0 : {1'b0, b_sat};
        job_new.t1 = prev_empty_reg ? cspan_pkg::NO_ROW : {1'b0, prev_top_reg};
        job_new.b1 = prev_empty_reg ? '0 : {1'b0, prev_bottom_reg};

        prev_empty_next  = prev_empty_reg;
        prev_top_next    = prev_top_reg;
        prev_bottom_next = prev_bottom_reg;
        if (accept)
        begin
            prev_empty_next  = col.col_empty;
            prev_top_next    = col.col_empty ? '0 : col.col_top;
            prev_bottom_next = col.col_empty ? '0 : b_sat;
        end

        wr_ptr_next = accept ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = deq ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (cspan_pkg::JQ_AW + 1)'(accept)
                    - (cspan_pkg::JQ_AW + 1)'(deq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_empty_reg  <= 1'b1;
            prev_top_reg    <= '0;
            prev_bottom_reg <= '0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            cnt_reg         <= '0;
        end
        else
        begin
            prev_empty_reg  <= prev_empty_next;
            prev_top_reg    <= prev_top_next;
            prev_bottom_reg <= prev_bottom_next;
            wr_ptr_reg      <= wr_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;
            cnt_reg         <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            jq_mem[wr_ptr_reg] <= job_new;
        end
    end

endmodule

// ===== design/cspan_back.sv =====
// Back end: walks each job's closing and opening rows, one row a cycle when the
// result queue has room. Owns row start memory and result queue. Uses cspan_pkg.
module cspan_back #(
    parameter int ROWS = cspan_pkg::ROWS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cspan_pkg::job_t  job,
    input  logic             job_valid,
    output logic             job_pop,
    output cspan_pkg::span_t span,
    output logic             empty,
    input  logic             pop
);

    localparam int AW = $clog2(ROWS);

    cspan_pkg::bk_state_t state_reg, state_next;

    logic [cspan_pkg::XW-1:0] x_reg, x_next;
    logic [cspan_pkg::RW-1:0] t1_reg, t1_next;
    logic [cspan_pkg::RW-1:0] b1_reg, b1_next;
    logic [cspan_pkg::RW-1:0] t2_reg, t2_next;
    logic [cspan_pkg::RW-1:0] b2_reg, b2_next;

    logic [cspan_pkg::SXW-1:0] start_mem [ROWS];
    logic [cspan_pkg::SXW-1:0] rd_data_reg;

    logic                      s1_valid_reg;
    logic [5:0]                s1_row_reg;
    logic [cspan_pkg::SXW-1:0] s1_end_reg;
    logic                      s1_last_reg;

    cspan_pkg::span_t          oq_mem [cspan_pkg::OQ_DEPTH];
    logic [cspan_pkg::OQ_AW-1:0] oq_wr_reg, oq_rd_reg;
    logic [cspan_pkg::OQ_CW-1:0] oq_cnt_reg;

    logic top_go, bot_go, opt_go, opb_go, done;
    logic room;
    logic [cspan_pkg::RW-1:0] t1_inc, b1_dec;
    logic [cspan_pkg::XW-1:0] x_end;

    logic                     emit;
    logic [cspan_pkg::RW-1:0] emit_row;
    logic                     emit_last;
    logic                     wr_en;
    logic [cspan_pkg::RW-1:0] wr_row;
    logic                     load;
    logic                     oq_push, oq_pop;

    always_comb
    begin
        top_go = (t1_reg < t2_reg) && (t1_reg <= b1_reg);
        bot_go = (b1_reg > b2_reg) && (b1_reg >= t1_reg);
        opt_go = (t2_reg < t1_reg) && (t2_reg <= b2_reg);
        opb_go = (b2_reg > b1_reg) && (b2_reg >= t2_reg);
        done   = !top_go && !bot_go && !opt_go && !opb_go;
        t1_inc = t1_reg + 1'b1;
        b1_dec = b1_reg - 1'b1;
        x_end  = x_reg - 1'b1;
        room   = (oq_cnt_reg + cspan_pkg::OQ_CW'(s1_valid_reg))
               < cspan_pkg::OQ_CW'(cspan_pkg::OQ_DEPTH);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cspan_pkg::BK_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = cspan_pkg::BK_RUN;
                end
            end
            cspan_pkg::BK_RUN:
            begin
                if (done && !job_valid)
                begin
                    state_next = cspan_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = cspan_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        x_next    = x_reg;
        t1_next   = t1_reg;
        b1_next   = b1_reg;
        t2_next   = t2_reg;
        b2_next   = b2_reg;
        emit      = 1'b0;
        emit_row  = t1_reg;
        emit_last = 1'b0;
        wr_en     = 1'b0;
        wr_row    = t2_reg;
        load      = 1'b0;
        case (state_reg)
            cspan_pkg::BK_IDLE:
            begin
                load = job_valid;
            end
            cspan_pkg::BK_RUN:
            begin
                if (top_go)
                begin
                    emit      = room;
                    emit_row  = t1_reg;
                    emit_last = !((t1_inc < t2_reg) && (t1_inc <= b1_reg))
                             && !((b1_reg > b2_reg) && (b1_reg >= t1_inc));
                    if (room)
                    begin
                        t1_next = t1_inc;
                    end
                end
                else if (bot_go)
                begin
                    emit      = room;
                    emit_row  = b1_reg;
                    emit_last = !((b1_dec > b2_reg) && (b1_dec >= t1_reg));
                    if (room)
                    begin
                        b1_next = b1_dec;
                    end
                end
                else if (opt_go)
                begin
                    wr_en   = 1'b1;
                    wr_row  = t2_reg;
                    t2_next = t2_reg + 1'b1;
                end
                else if (opb_go)
                begin
                    wr_en   = 1'b1;
                    wr_row  = b2_reg;
                    b2_next = b2_reg - 1'b1;
                end
                else
                begin
                    load = job_valid;
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
        if (load)
        begin
            x_next  = job.x;
            t1_next = job.t1;
            b1_next = job.b1;
            t2_next = job.t2;
            b2_next = job.b2;
        end
    end

    assign job_pop = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cspan_pkg::BK_IDLE;
            t1_reg    <= cspan_pkg::NO_ROW;
            b1_reg    <= '0;
            t2_reg    <= cspan_pkg::NO_ROW;
            b2_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            t1_reg    <= t1_next;
            b1_reg    <= b1_next;
            t2_reg    <= t2_next;
            b2_reg    <= b2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
    end

    // row start store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_mem[wr_row[AW-1:0]] <= x_reg[cspan_pkg::SXW-1:0];
        end
        if (emit)
        begin
            rd_data_reg <= start_mem[emit_row[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            s1_row_reg  <= emit_row[5:0];
            s1_end_reg  <= x_end[cspan_pkg::SXW-1:0];
            s1_last_reg <= emit_last;
        end
    end

    // result queue
    assign empty   = (oq_cnt_reg == '0);
    assign oq_pop  = pop && !empty;
    assign oq_push = s1_valid_reg;
    assign span    = oq_mem[oq_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (oq_push)
            begin
                oq_wr_reg <= oq_wr_reg + 1'b1;
            end
            if (oq_pop)
            begin
                oq_rd_reg <= oq_rd_reg + 1'b1;
            end
            oq_cnt_reg <= oq_cnt_reg + cspan_pkg::OQ_CW'(oq_push)
                        - cspan_pkg::OQ_CW'(oq_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_mem[oq_wr_reg].span_row     <= s1_row_reg;
            oq_mem[oq_wr_reg].span_x_start <= rd_data_reg;
            oq_mem[oq_wr_reg].span_x_end   <= s1_end_reg;
            oq_mem[oq_wr_reg].span_last    <= s1_last_reg;
        end
    end

endmodule

// ===== design/cspan_checker.sv =====
// Port-level checks for column_to_span_converter_core, bound to the top level.
// Depends on cspan_pkg.
module cspan_checker #(
    parameter int ROWS = cspan_pkg::ROWS_DEF
) (
    input logic             clk,
    input logic             rst_n,
    input logic             full,
    input cspan_pkg::span_t span,
    input logic             empty,
    input logic             pop
);

    a_reset_clear: assert property (@(posedge clk) !rst_n |=> empty && !full)
        else $error("queues not cleared in reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(span))
        else $error("waiting span changed");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> span.span_row <= 6'(ROWS - 1))
        else $error("span row out of range");

    a_same_col: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && !span.span_last ##1 !empty
        |-> span.span_x_end == $past(span.span_x_end))
        else $error("spans of one column disagree on end column");

endmodule

bind column_to_span_converter_core cspan_checker #(.ROWS(ROWS)) u_cspan_checker (.*);
